// ===== rtl/core/rnra_pkg.sv =====
// ----------------------------------------------------------------------------
// rnra_pkg
// Types and constants shared by the ring neighbor resource arbiter modules.
// ----------------------------------------------------------------------------
package rnra_pkg;

  localparam int SEAT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [COUNT_W-1:0] SEAT_COUNT_RESET = 5'd5;
  localparam logic               REG_SEAT_COUNT   = 1'b0;

  localparam logic CMD_TAKE    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    PH_THINKING = 2'd0,
    PH_HUNGRY   = 2'd1,
    PH_EATING   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_GRANT1,
    S_GRANT2,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_CHECK,
    DP_GRANT_FIRST,
    DP_GRANT_SECOND,
    DP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad;
    logic release_cmd;
  } dp_status_t;

endpackage

// ===== rtl/core/rnra_datapath.sv =====
// ----------------------------------------------------------------------------
// rnra_datapath
// Seat phase cells, neighbor grant logic, working result and output word.
// ----------------------------------------------------------------------------
module rnra_datapath import rnra_pkg::*; #(
  parameter int MAX_SEATS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          ctl,
  output dp_status_t         status,
  input  logic [COUNT_W-1:0] seat_count,
  input  logic               cmd,
  input  logic [SEAT_W-1:0]  seat,
  output logic               first_valid,
  output logic [SEAT_W-1:0]  first_seat,
  output logic               second_valid,
  output logic [SEAT_W-1:0]  second_seat,
  output logic               error
);

  localparam int IDX_W = $clog2(MAX_SEATS);
  localparam int CNT_W = $clog2(MAX_SEATS + 1);
  localparam int CMP_W = (CNT_W > SEAT_W) ? CNT_W : SEAT_W;

  phase_t               phase      [MAX_SEATS];
  phase_t               phase_next [MAX_SEATS];
  logic [1:0]           up_ph      [MAX_SEATS];
  logic [1:0]           dn_ph      [MAX_SEATS];
  logic [MAX_SEATS-1:0] sel;
  logic [MAX_SEATS-1:0] is_last;
  logic [MAX_SEATS-1:0] can;
  logic [1:0]           cur_ph;
  logic [1:0]           last_ph;
  logic                 grant;
  logic [CNT_W-1:0]     n;
  logic [IDX_W-1:0]     hi_idx;
  logic [IDX_W-1:0]     lo_idx;

  logic                 cmd_q;
  logic [SEAT_W-1:0]    seat_q;
  logic [IDX_W-1:0]     target;
  logic [IDX_W-1:0]     lo_q;
  logic                 res_fv;
  logic [SEAT_W-1:0]    res_fs;
  logic                 res_sv;
  logic [SEAT_W-1:0]    res_ss;
  logic                 res_err;

  always_comb begin
    if (seat_count == '0) begin
      n = CNT_W'(1);
    end else if (int'(seat_count) > MAX_SEATS) begin
      n = CNT_W'(MAX_SEATS);
    end else begin
      n = CNT_W'(seat_count);
    end
  end

  for (genvar i = 0; i < MAX_SEATS; i++) begin : g_cell
    assign sel[i]     = (target == IDX_W'(i));
    assign is_last[i] = (CNT_W'(i + 1) == n);
    assign up_ph[i]   = is_last[i] ? phase[0] : phase[(i + 1) % MAX_SEATS];
    if (i == 0) begin : g_first
      assign dn_ph[i] = last_ph;
    end else begin : g_rest
      assign dn_ph[i] = phase[i - 1];
    end
    assign can[i] = (phase[i] == PH_HUNGRY) && (up_ph[i] != PH_EATING)
                    && (dn_ph[i] != PH_EATING);
  end

  always_comb begin
    cur_ph  = '0;
    last_ph = '0;
    for (int i = 0; i < MAX_SEATS; i++) begin
      if (sel[i]) begin
        cur_ph = cur_ph | phase[i];
      end
      if (is_last[i]) begin
        last_ph = last_ph | phase[i];
      end
    end
  end

  assign grant  = |(sel & can);
  assign hi_idx = (CNT_W'(target) + CNT_W'(1) == n) ? '0 : target + IDX_W'(1);
  assign lo_idx = (target == '0) ? IDX_W'(n - CNT_W'(1)) : target - IDX_W'(1);

  assign status.release_cmd = (cmd_q == CMD_RELEASE);
  assign status.bad = (CMP_W'(seat_q) >= CMP_W'(n))
                      || ((cmd_q == CMD_TAKE) ? (cur_ph != PH_THINKING)
                                              : (cur_ph != PH_EATING));

  always_comb begin
    for (int i = 0; i < MAX_SEATS; i++) begin
      phase_next[i] = phase[i];
      case (ctl.op)
        DP_CHECK: begin
          if (sel[i] && !status.bad) begin
            phase_next[i] = (cmd_q == CMD_TAKE) ? PH_HUNGRY : PH_THINKING;
          end
        end
        DP_GRANT_FIRST, DP_GRANT_SECOND: begin
          if (sel[i] && can[i]) begin
            phase_next[i] = PH_EATING;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SEATS; i++) begin
        phase[i] <= PH_THINKING;
      end
    end else begin
      for (int i = 0; i < MAX_SEATS; i++) begin
        phase[i] <= phase_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      DP_LOAD: begin
        cmd_q  <= cmd;
        seat_q <= seat;
        target <= IDX_W'(seat);
      end
      DP_CHECK: begin
        res_err <= status.bad;
        res_fv  <= 1'b0;
        res_fs  <= '0;
        res_sv  <= 1'b0;
        res_ss  <= '0;
        lo_q    <= lo_idx;
        if (status.release_cmd) begin
          target <= hi_idx;
        end
      end
      DP_GRANT_FIRST: begin
        if (grant) begin
          res_fv <= 1'b1;
          res_fs <= SEAT_W'(target);
        end
        target <= lo_q;
      end
      DP_GRANT_SECOND: begin
        if (grant) begin
          res_sv <= 1'b1;
          res_ss <= SEAT_W'(target);
        end
      end
      DP_PUBLISH: begin
        first_valid  <= res_fv;
        first_seat   <= res_fs;
        second_valid <= res_sv;
        second_seat  <= res_ss;
        error        <= res_err;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_err_no_grant: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == DP_PUBLISH) |-> !(res_err && (res_fv || res_sv)))
    else $error("Error word carries a grant.");
`endif

endmodule

// ===== rtl/core/rnra_ctrl.sv =====
// ----------------------------------------------------------------------------
// rnra_ctrl
// Sequencer for check, grant steps and output word handoff.
// ----------------------------------------------------------------------------
module rnra_ctrl import rnra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  ctl
);

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op     = DP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = DP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.op     = DP_CHECK;
        state_next = status.bad ? S_DONE : S_GRANT1;
      end
      S_GRANT1: begin
        ctl.op     = DP_GRANT_FIRST;
        state_next = status.release_cmd ? S_GRANT2 : S_DONE;
      end
      S_GRANT2: begin
        ctl.op     = DP_GRANT_SECOND;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_full || !out_stall) begin
          ctl.op     = DP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (ctl.op == DP_PUBLISH) begin
      out_full_next = 1'b1;
    end else if (out_full && !out_stall) begin
      out_full_next = 1'b0;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = out_full;

`ifndef SYNTH
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_CHECK))
    else $error("Accepted word did not move to the check step.");
  a_second_after_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_GRANT2) |-> ($past(state) == S_GRANT1))
    else $error("Second grant step without a first grant step.");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == DP_PUBLISH) |-> !(out_full && out_stall))
    else $error("Output word overwritten while stalled.");
`endif

endmodule

// ===== rtl/core/ring_neighbor_resource_arbiter_unit.sv =====
// ----------------------------------------------------------------------------
// ring_neighbor_resource_arbiter_unit: dining-philosophers seat arbiter.
// Steps: check, first grant, second grant (release only), done; an error skips to done.
// A new word is accepted only in idle, once the last result word is published (held by out_stall).
// Reset sets all seats thinking and seat_count to 5.
// ----------------------------------------------------------------------------
module ring_neighbor_resource_arbiter_unit import rnra_pkg::*; #(
  parameter int MAX_SEATS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [SEAT_W-1:0] seat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              first_valid,
  output logic [SEAT_W-1:0] first_seat,
  output logic              second_valid,
  output logic [SEAT_W-1:0] second_seat,
  output logic              error
);

  logic [COUNT_W-1:0] seat_count;
  logic               reg_write;
  ctrl_cmd_t          ctl;
  dp_status_t         status;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seat_count <= SEAT_COUNT_RESET;
    end else if (reg_write && (paddr[2] == REG_SEAT_COUNT)) begin
      seat_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SEAT_COUNT) ? DATA_W'(seat_count) : '0;

  rnra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .ctl       (ctl)
  );

  rnra_datapath #(
    .MAX_SEATS (MAX_SEATS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .status       (status),
    .seat_count   (seat_count),
    .cmd          (cmd),
    .seat         (seat),
    .first_valid  (first_valid),
    .first_seat   (first_seat),
    .second_valid (second_valid),
    .second_seat  (second_seat),
    .error        (error)
  );

endmodule

// ===== tb/sv/seat_grant_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seat_grant_checker
// Watches the request, result and register ports of the ring neighbor
// resource arbiter, tracks each seat's phase as requests are accepted, and
// compares every result word with the grant predicted for its request.
// ----------------------------------------------------------------------------
module seat_grant_checker import rnra_pkg::*; #(
  parameter int MAX_SEATS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 cmd,
  input  logic [SEAT_W-1:0]    seat,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 first_valid,
  input  logic [SEAT_W-1:0]    first_seat,
  input  logic                 second_valid,
  input  logic [SEAT_W-1:0]    second_seat,
  input  logic                 error,
  output int                   fail_count,
  output int                   words_waiting,
  output int                   ring_seats,
  output logic [MAX_SEATS-1:0] eating_seats,
  output logic [MAX_SEATS-1:0] thinking_seats
);

  typedef struct packed {
    logic              first_valid;
    logic [SEAT_W-1:0] first_seat;
    logic              second_valid;
    logic [SEAT_W-1:0] second_seat;
    logic              error;
  } grant_word_t;

  phase_t             seat_phase [MAX_SEATS];
  logic [COUNT_W-1:0] seat_count;
  grant_word_t        grants_due [$];
  int                 mismatches;

  function automatic int unsigned ring_size();
    if (seat_count == 0) return 1;
    if (seat_count > MAX_SEATS) return MAX_SEATS;
    return seat_count;
  endfunction

  function automatic bit seat_granted(int unsigned s, int unsigned n);
    if (seat_phase[s] == PH_HUNGRY && seat_phase[(s + 1) % n] != PH_EATING &&
        seat_phase[(s + n - 1) % n] != PH_EATING) begin
      seat_phase[s] = PH_EATING;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic grant_word_t arbitrate(logic op, logic [SEAT_W-1:0] s);
    grant_word_t w;
    int unsigned n;
    int unsigned hi;
    int unsigned lo;
    w = '0;
    n = ring_size();
    if (s >= n) begin
      w.error = 1'b1;
    end else if (op == CMD_TAKE) begin
      if (seat_phase[s] != PH_THINKING) begin
        w.error = 1'b1;
      end else begin
        seat_phase[s] = PH_HUNGRY;
        if (seat_granted(s, n)) begin
          w.first_valid = 1'b1;
          w.first_seat  = s;
        end
      end
    end else begin
      if (seat_phase[s] != PH_EATING) begin
        w.error = 1'b1;
      end else begin
        hi = (s + 1) % n;
        lo = (s + n - 1) % n;
        seat_phase[s] = PH_THINKING;
        if (seat_granted(hi, n)) begin
          w.first_valid = 1'b1;
          w.first_seat  = SEAT_W'(hi);
        end
        if (seat_granted(lo, n)) begin
          w.second_valid = 1'b1;
          w.second_seat  = SEAT_W'(lo);
        end
      end
    end
    return w;
  endfunction

  always @(posedge clk) begin : watch
    grant_word_t seen;
    grant_word_t due;
    if (rst) begin
      foreach (seat_phase[i]) seat_phase[i] = PH_THINKING;
      seat_count = SEAT_COUNT_RESET;
      grants_due.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_W'(4 * REG_SEAT_COUNT))
        seat_count = pwdata[COUNT_W-1:0];
      if (out_valid && !out_stall) begin
        seen = {first_valid, first_seat, second_valid, second_seat, error};
        if (grants_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word: fv=%0d fs=%0d sv=%0d ss=%0d err=%0d",
                     $time, seen.first_valid, seen.first_seat, seen.second_valid,
                     seen.second_seat, seen.error);
        end else begin
          due = grants_due.pop_front();
          if (seen.first_valid !== due.first_valid || seen.first_seat !== due.first_seat ||
              seen.second_valid !== due.second_valid ||
              seen.second_seat !== due.second_seat || seen.error !== due.error) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: grant mismatch: expected fv=%0d fs=%0d sv=%0d ss=%0d err=%0d",
                       $time, due.first_valid, due.first_seat, due.second_valid,
                       due.second_seat, due.error);
              $display("%0t: grant mismatch: got      fv=%0d fs=%0d sv=%0d ss=%0d err=%0d",
                       $time, seen.first_valid, seen.first_seat, seen.second_valid,
                       seen.second_seat, seen.error);
            end
          end
        end
      end
      if (in_valid && !in_stall) grants_due.push_back(arbitrate(cmd, seat));
    end
    fail_count    <= mismatches;
    words_waiting <= grants_due.size();
    ring_seats    <= ring_size();
    for (int i = 0; i < MAX_SEATS; i++) begin
      eating_seats[i]   <= (seat_phase[i] == PH_EATING);
      thinking_seats[i] <= (seat_phase[i] == PH_THINKING);
    end
  end

endmodule

// ===== tb/sv/ring_neighbor_resource_arbiter_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_neighbor_resource_arbiter_unit_test
// Drives take and release requests into the seat arbiter under several seat
// counts, mostly legal for the current seat phases with some random noise,
// with random idle and stall bursts, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module ring_neighbor_resource_arbiter_unit_test;
  import rnra_pkg::*;

  localparam int SEATS = 16;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              cmd = CMD_TAKE;
  logic [SEAT_W-1:0] seat = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              first_valid;
  logic [SEAT_W-1:0] first_seat;
  logic              second_valid;
  logic [SEAT_W-1:0] second_seat;
  logic              error;

  int                fail_count;
  int                words_waiting;
  int                ring_seats;
  logic [SEATS-1:0]  eating_seats;
  logic [SEATS-1:0]  thinking_seats;
  logic [SEATS-1:0]  last_mask = '0;
  bit                calm = 1'b0;
  int                stall_left = 0;

  logic [COUNT_W-1:0] phase_counts [9] = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd7, 5'd2, 5'd17,
                                           5'd1, 5'd16};

  always #1 clk = ~clk;

  ring_neighbor_resource_arbiter_unit #(.MAX_SEATS(SEATS)) dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .seat(seat),
    .out_valid(out_valid), .out_stall(out_stall), .first_valid(first_valid),
    .first_seat(first_seat), .second_valid(second_valid),
    .second_seat(second_seat), .error(error)
  );

  seat_grant_checker #(.MAX_SEATS(SEATS)) grant_check (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata), .in_valid(in_valid),
    .in_stall(in_stall), .cmd(cmd), .seat(seat), .out_valid(out_valid),
    .out_stall(out_stall), .first_valid(first_valid), .first_seat(first_seat),
    .second_valid(second_valid), .second_seat(second_seat), .error(error),
    .fail_count(fail_count), .words_waiting(words_waiting),
    .ring_seats(ring_seats), .eating_seats(eating_seats),
    .thinking_seats(thinking_seats)
  );

  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic offer_word(input logic op, input logic [SEAT_W-1:0] s);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    seat     <= s;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    last_mask = SEATS'(1) << s;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_waiting != 0);
    @(posedge clk);
  endtask

  task automatic write_seat_count(input logic [COUNT_W-1:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * REG_SEAT_COUNT);
    pwdata  <= DATA_W'({$urandom, value});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SEAT_W-1:0] pick_seat(logic [SEATS-1:0] pool);
    int s;
    do s = $urandom_range(0, SEATS - 1); while (!pool[s]);
    return SEAT_W'(s);
  endfunction

  // Seat phases seen here lag the word just accepted, so its seat is left out.
  task automatic offer_random();
    logic [SEATS-1:0] live;
    logic [SEATS-1:0] can_take;
    logic [SEATS-1:0] can_drop;
    live     = SEATS'((32'd1 << ring_seats) - 1);
    can_take = thinking_seats & live & ~last_mask;
    can_drop = eating_seats & live & ~last_mask;
    if ($urandom_range(0, 99) < 15 || (can_take == '0 && can_drop == '0))
      offer_word(1'($urandom_range(0, 1)), SEAT_W'($urandom_range(0, SEATS - 1)));
    else if (can_drop != '0 && (can_take == '0 || $urandom_range(0, 1) == 1))
      offer_word(CMD_RELEASE, pick_seat(can_drop));
    else
      offer_word(CMD_TAKE, pick_seat(can_take));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_word(CMD_TAKE, 4'd0);
    offer_word(CMD_TAKE, 4'd1);
    offer_word(CMD_TAKE, 4'd3);
    offer_word(CMD_TAKE, 4'd2);
    offer_word(CMD_RELEASE, 4'd0);
    offer_word(CMD_TAKE, 4'd1);
    offer_word(CMD_RELEASE, 4'd2);
    offer_word(CMD_RELEASE, 4'd4);
    offer_word(CMD_TAKE, 4'd5);
    offer_word(CMD_RELEASE, 4'd15);
    offer_word(CMD_RELEASE, 4'd1);
    offer_word(CMD_TAKE, 4'd4);
    offer_word(CMD_RELEASE, 4'd3);
    offer_word(CMD_RELEASE, 4'd4);
    offer_word(CMD_RELEASE, 4'd2);

    write_seat_count(5'd1);
    offer_word(CMD_TAKE, 4'd0);
    offer_word(CMD_TAKE, 4'd0);
    offer_word(CMD_RELEASE, 4'd0);
    offer_word(CMD_RELEASE, 4'd0);
    offer_word(CMD_TAKE, 4'd1);

    write_seat_count(5'd2);
    offer_word(CMD_TAKE, 4'd0);
    offer_word(CMD_TAKE, 4'd1);
    offer_word(CMD_RELEASE, 4'd0);
    offer_word(CMD_RELEASE, 4'd1);

    foreach (phase_counts[p]) begin
      write_seat_count(phase_counts[p]);
      if (p == $size(phase_counts) - 1) calm <= 1'b1;
      repeat (50) offer_random();
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("Test completed with failures");
    $finish;
  end

endmodule
